FILE: hdl/gfsr_pkg.sv
// shared types and constants for the gfsr gaussian noise generator
package gfsr_pkg;

    localparam int WORD_W   = 32;
    localparam int TBL_W    = 16;
    localparam int TBL_AW   = 11;
    localparam int SCALE_W  = 40;
    localparam int FRAC_W   = 22;
    localparam int FIELD_W  = 9;
    localparam int NUM_SEG  = 4;
    localparam int SEG_W    = 2;
    localparam int COUNT_W  = 7;
    localparam int U_W      = SCALE_W + 1;
    localparam int SUM_W    = 60;

    typedef logic [SCALE_W-1:0] scale_t;

    typedef enum logic [1:0] {
        ACT_GEN   = 2'd0,
        ACT_SEED  = 2'd1,
        ACT_TABLE = 2'd2,
        ACT_RSVD  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_XOR,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_SUM,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic load_seed;
        logic load_tbl;
        logic tap_step;
        logic xor_step;
        logic mul1;
        logic mul2;
        logic mul3;
        logic sum_real;
        logic sum_imag;
        logic push;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

FILE: hdl/gfsr_ctrl.sv
// request sequencer for the gfsr gaussian noise generator
module gfsr_ctrl #(
    parameter int MAX_PAIRS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [1:0]                    action,
    input  logic [gfsr_pkg::COUNT_W-1:0]  pair_count,
    input  gfsr_pkg::status_t             status,
    output gfsr_pkg::cmd_t                cmd
);
    import gfsr_pkg::*;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] remain_reg, remain_next;
    logic               imag_reg, imag_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            remain_reg <= '0;
            imag_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            remain_reg <= remain_next;
            imag_reg   <= imag_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        remain_next = remain_reg;
        imag_next   = imag_reg;
        s_tready    = 1'b0;
        cmd         = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (action)
                        ACT_SEED:  cmd.load_seed = 1'b1;
                        ACT_TABLE: cmd.load_tbl  = 1'b1;
                        ACT_GEN: begin
                            if (pair_count != '0) begin
                                remain_next = (pair_count > COUNT_W'(MAX_PAIRS)) ?
                                              COUNT_W'(MAX_PAIRS) : pair_count;
                                imag_next   = 1'b0;
                                state_next  = ST_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                cmd.tap_step = 1'b1;
                state_next   = ST_XOR;
            end
            ST_XOR: begin
                cmd.xor_step = 1'b1;
                state_next   = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = ST_MUL3;
            end
            ST_MUL3: begin
                cmd.mul3   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                if (!imag_reg) begin
                    cmd.sum_real = 1'b1;
                    imag_next    = 1'b1;
                    state_next   = ST_READ;
                end else begin
                    cmd.sum_imag = 1'b1;
                    state_next   = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (status.out_free) begin
                    cmd.push    = 1'b1;
                    cmd.last    = (remain_reg == COUNT_W'(1));
                    imag_next   = 1'b0;
                    remain_next = remain_reg - COUNT_W'(1);
                    state_next  = cmd.last ? ST_IDLE : ST_READ;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> status.out_free) else $error("push into a full output slot");
    a_remain_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (remain_reg != '0)) else $error("pair count ran out");
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.push && cmd.last) |=> (state_reg == ST_IDLE)) else $error("no return to idle");
`endif

endmodule

FILE: hdl/gfsr_dp.sv
// seed register, table lookup and interpolation datapath
module gfsr_dp #(
    parameter int LONG_LAG  = 98,
    parameter int SHORT_LAG = 27
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  gfsr_pkg::cmd_t                    cmd,
    output gfsr_pkg::status_t                 status,
    input  logic [gfsr_pkg::TBL_AW-1:0]       load_addr,
    input  logic [gfsr_pkg::WORD_W-1:0]       load_data,
    input  gfsr_pkg::scale_t [gfsr_pkg::NUM_SEG-1:0] scale,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,
    output logic                              m_tlast
);
    import gfsr_pkg::*;

    localparam int TAP_W = $clog2(LONG_LAG);

    logic [WORD_W-1:0] seed_mem [LONG_LAG];
    logic [TBL_W-1:0]  tbl_mem  [2**TBL_AW];

    logic [TAP_W-1:0]  tap_a_reg, tap_b_reg, tap_a_next, tap_b_next;
    logic [WORD_W-1:0] rd_a_reg, rd_b_reg, x_word;
    logic              seed_we;
    logic [TAP_W-1:0]  seed_wa;
    logic [WORD_W-1:0] seed_wd;

    logic [TBL_AW-1:0] base_addr;
    logic [FRAC_W-1:0] frac_sel;
    logic [SEG_W-1:0]  seg_sel;
    logic [FRAC_W-1:0] frac_reg;
    logic [SEG_W-1:0]  seg_reg;
    logic              sign_reg;
    logic signed [TBL_W-1:0] t0_reg, t1_reg;

    scale_t            scale_cur;
    logic [41:0]       plo_reg, phi_reg;
    logic [61:0]       u_full;
    logic [U_W-1:0]    u_reg;
    logic signed [TBL_W:0] diff_reg;
    logic signed [38:0] qlo_reg;
    logic signed [37:0] qhi_reg;
    logic signed [SUM_W-1:0] sum_val;
    logic signed [19:0] y_round;
    logic signed [20:0] y_neg;
    logic signed [TBL_W-1:0] y_sat;
    logic [TBL_W-1:0]  real_reg, imag_reg;
    logic              m_valid_reg;
    logic [31:0]       m_data_reg;
    logic              m_last_reg;

    // tap advance with wrap
    always_comb begin
        tap_a_next = (tap_a_reg == TAP_W'(LONG_LAG - 1)) ? '0 : tap_a_reg + TAP_W'(1);
        tap_b_next = (tap_b_reg == TAP_W'(LONG_LAG - 1)) ? '0 : tap_b_reg + TAP_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_a_reg <= TAP_W'(LONG_LAG - 1);
            tap_b_reg <= TAP_W'(SHORT_LAG - 1);
        end else if (cmd.tap_step) begin
            tap_a_reg <= tap_a_next;
            tap_b_reg <= tap_b_next;
        end
    end

    assign x_word  = rd_a_reg ^ rd_b_reg;
    assign seed_we = (cmd.load_seed && (32'(load_addr) < 32'(LONG_LAG))) || cmd.xor_step;
    assign seed_wa = cmd.xor_step ? tap_a_reg : load_addr[TAP_W-1:0];
    assign seed_wd = cmd.xor_step ? x_word : load_data;

    always_ff @(posedge aclk) begin
        if (seed_we) begin
            seed_mem[seed_wa] <= seed_wd;
        end
        if (cmd.tap_step) begin
            rd_a_reg <= seed_mem[tap_a_next];
            rd_b_reg <= seed_mem[tap_b_next];
        end
    end

    // segment decode
    always_comb begin
        if (x_word[30:25] != 6'h3f) begin
            base_addr = {2'd0, x_word[30:22]};
            frac_sel  = x_word[21:0];
            seg_sel   = 2'd0;
        end else if (x_word[24:19] != 6'h3f) begin
            base_addr = {2'd1, x_word[24:16]};
            frac_sel  = FRAC_W'(x_word[15:0]);
            seg_sel   = 2'd1;
        end else if (x_word[18:13] != 6'h3f) begin
            base_addr = {2'd2, x_word[18:10]};
            frac_sel  = FRAC_W'(x_word[9:0]);
            seg_sel   = 2'd2;
        end else if (x_word[12:4] != 9'h1ff) begin
            base_addr = {2'd3, x_word[12:4]};
            frac_sel  = FRAC_W'(x_word[3:0]);
            seg_sel   = 2'd3;
        end else begin
            // tail entry, no interpolation
            base_addr = '1;
            frac_sel  = '0;
            seg_sel   = 2'd3;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_tbl) begin
            tbl_mem[load_addr] <= load_data[TBL_W-1:0];
        end
        if (cmd.xor_step) begin
            t0_reg   <= tbl_mem[base_addr];
            t1_reg   <= tbl_mem[base_addr + TBL_AW'(1)];
            frac_reg <= frac_sel;
            seg_reg  <= seg_sel;
            sign_reg <= x_word[31];
        end
    end

    assign scale_cur = scale[seg_reg];
    assign u_full    = 62'(plo_reg) + (62'(phi_reg) << 20);
    assign sum_val   = (SUM_W'(t0_reg) <<< 40) + SUM_W'(qlo_reg) + (SUM_W'(qhi_reg) <<< 21);
    assign y_round   = 20'((sum_val + (SUM_W'(1) <<< 39)) >>> 40);
    assign y_neg     = sign_reg ? -21'(y_round) : 21'(y_round);
    assign y_sat     = (y_neg > 21'sd32767) ? 16'sh7fff :
                       (y_neg < -21'sd32768) ? 16'sh8000 : TBL_W'(y_neg);

    always_ff @(posedge aclk) begin
        if (cmd.mul1) begin
            plo_reg <= 42'(scale_cur[19:0] * frac_reg);
            phi_reg <= 42'(scale_cur[39:20] * frac_reg);
        end
        if (cmd.mul2) begin
            u_reg    <= (u_full > 62'h100_0000_0000) ? U_W'(41'h100_0000_0000) : U_W'(u_full);
            diff_reg <= 17'(t1_reg) - 17'(t0_reg);
        end
        if (cmd.mul3) begin
            qlo_reg <= 39'(diff_reg * $signed({1'b0, u_reg[20:0]}));
            qhi_reg <= 38'(diff_reg * $signed({1'b0, u_reg[40:21]}));
        end
        if (cmd.sum_real) begin
            real_reg <= y_sat;
        end
        if (cmd.sum_imag) begin
            imag_reg <= y_sat;
        end
        if (cmd.push) begin
            m_data_reg <= {imag_reg, real_reg};
            m_last_reg <= cmd.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_tap_lag: assert property (@(posedge aclk) disable iff (!aresetn)
        ((tap_a_reg >= tap_b_reg) ? (32'(tap_a_reg) - 32'(tap_b_reg))
                                  : (32'(tap_a_reg) + LONG_LAG - 32'(tap_b_reg)))
        == (LONG_LAG - SHORT_LAG)) else $error("tap spacing lost");
    a_push_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |=> m_tvalid) else $error("pushed pair not presented");
    a_tap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(tap_a_reg) < LONG_LAG) else $error("tap index out of range");
`endif

endmodule

FILE: hdl/gfsr_gaussian_noise_generator.sv
// top level of the gfsr gaussian noise generator
//
//  port group | dir | contents
//  s_*        | in  | requests: generate pairs, load seed word, load table entry
//  m_*        | out | complex gaussian pairs, tlast on the final pair
//  apb        | in  | four 40-bit segment scale registers at 8*i
//
// each deviate passes through seed read, xor/table read, three multiply
// stages and sum; a pair is a real and then an imaginary deviate followed
// by a push, and loads complete in the idle state. the output register holds
// one pair; the sequencer stalls at push while it is occupied and not accepted.
// aresetn is synchronous; seed and table memories are not cleared.
module gfsr_gaussian_noise_generator #(
    parameter int LONG_LAG  = 98,
    parameter int SHORT_LAG = 27,
    parameter int MAX_PAIRS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // load_addr[10:0], load_data[42:11], pair_count[49:43]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // real_part[15:0], imag_part[31:16]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import gfsr_pkg::*;

    scale_t [NUM_SEG-1:0] scale_reg;
    cmd_t                 cmd;
    status_t              status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg[0] <= SCALE_W'(40'd262144);
            scale_reg[1] <= SCALE_W'(40'd16777216);
            scale_reg[2] <= SCALE_W'(40'd1073741824);
            scale_reg[3] <= SCALE_W'(40'd68719476736);
        end else if (psel && penable && pwrite && pready) begin
            scale_reg[paddr[4:3]] <= pwdata[SCALE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = 64'(scale_reg[paddr[4:3]]);

    gfsr_ctrl #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .action     (s_tuser),
        .pair_count (s_tdata[49:43]),
        .status     (status),
        .cmd        (cmd)
    );

    gfsr_dp #(
        .LONG_LAG  (LONG_LAG),
        .SHORT_LAG (SHORT_LAG)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .load_addr (s_tdata[10:0]),
        .load_data (s_tdata[42:11]),
        .scale     (scale_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
